>>> rtl/core/clc_pkg.sv
package clc_pkg;

  // fixed-point formats
  localparam int F      = 4;    // coordinate fraction bits
  localparam int C      = 8;    // coverage fraction bits
  localparam int S      = F + 8;  // distance fraction bits
  localparam int IN_W   = 12;
  localparam int CRD_W  = 16;
  localparam int HW_W   = 12;
  localparam int COV_W  = 9;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X    = 3'd0,
    REG_START_Y    = 3'd1,
    REG_END_X      = 3'd2,
    REG_END_Y      = 3'd3,
    REG_HALF_WIDTH = 3'd4
  } cfg_reg_t;

  localparam logic [HW_W-1:0] HALF_WIDTH_RST = HW_W'(16);

  // datapath widths
  localparam int PX_W    = IN_W + F;
  localparam int DW      = ((PX_W > CRD_W) ? PX_W : CRD_W) + 1;
  localparam int NUM_W   = 2 * DW;
  localparam int SUM_W   = 2 * DW + 1;
  localparam int H_FRAC  = 16;
  localparam int H_W     = H_FRAC + 2;          // signed, holds 1.0
  localparam int DLW     = DW + H_FRAC + 2;
  localparam int RND_SH  = 8;
  localparam int EW      = DLW - RND_SH;
  localparam int QW      = 2 * EW + 1;
  localparam int SQ_STG  = (QW + 1) / 2;
  localparam int CW0     = (SQ_STG > HW_W + RND_SH) ? SQ_STG : HW_W + RND_SH;
  localparam int CW      = ((CW0 > S) ? CW0 : S) + 2;

  // coverage rescale
  localparam int SH_R    = (S > C) ? S - C : 0;
  localparam int SH_L    = (S > C) ? 0 : C - S;
  localparam int RS_W    = S + 2 + SH_L;

  typedef enum logic [1:0] {
    HM_ZERO = 2'd0,
    HM_DIV  = 2'd1,
    HM_FULL = 2'd2
  } h_mode_t;

  // side data carried along the divider
  typedef struct packed {
    logic                 zero;
    h_mode_t              mode;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] lx;
    logic signed [DW-1:0] ly;
  } div_tag_t;

endpackage

>>> rtl/core/clc_div.sv
module clc_div
  import clc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [NUM_W-1:0] in_den,
  input  div_tag_t         in_tag,
  output logic             out_valid,
  output logic [H_FRAC-1:0] out_quo,
  output div_tag_t         out_tag
);

  logic              v_r   [H_FRAC];
  logic [NUM_W-1:0]  rem_r [H_FRAC];
  logic [NUM_W-1:0]  den_r [H_FRAC];
  logic [H_FRAC-1:0] quo_r [H_FRAC];
  div_tag_t          tag_r [H_FRAC];

  // one quotient bit per stage, restoring
  for (genvar i = 0; i < H_FRAC; i++) begin : g_stg
    logic              vi;
    logic [NUM_W-1:0]  ri;
    logic [NUM_W-1:0]  di;
    logic [H_FRAC-1:0] qi;
    div_tag_t          ti;
    logic [NUM_W:0]    r2;
    logic              ge;
    logic [NUM_W:0]    diff;

    if (i == 0) begin : g_first
      assign vi = in_valid;
      assign ri = in_num;
      assign di = in_den;
      assign qi = '0;
      assign ti = in_tag;
    end else begin : g_next
      assign vi = v_r[i-1];
      assign ri = rem_r[i-1];
      assign di = den_r[i-1];
      assign qi = quo_r[i-1];
      assign ti = tag_r[i-1];
    end

    assign r2   = {ri, 1'b0};
    assign ge   = r2 >= {1'b0, di};
    assign diff = r2 - {1'b0, di};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= vi;
      end
      rem_r[i] <= ge ? diff[NUM_W-1:0] : r2[NUM_W-1:0];
      den_r[i] <= di;
      quo_r[i] <= {qi[H_FRAC-2:0], ge};
      tag_r[i] <= ti;
    end
  end

  assign out_valid = v_r[H_FRAC-1];
  assign out_quo   = quo_r[H_FRAC-1];
  assign out_tag   = tag_r[H_FRAC-1];

endmodule

>>> rtl/core/clc_sqrt.sv
module clc_sqrt
  import clc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [QW-1:0]     in_rad,
  input  logic              in_zero,
  output logic              out_valid,
  output logic [SQ_STG-1:0] out_root,
  output logic              out_zero
);

  logic          v_r   [SQ_STG];
  logic [QW-1:0] x_r   [SQ_STG];
  logic [QW-1:0] res_r [SQ_STG];
  logic          z_r   [SQ_STG];

  // one root bit per stage, digit by digit from the top
  for (genvar i = 0; i < SQ_STG; i++) begin : g_stg
    localparam logic [QW-1:0] BITV = QW'(1) << (2 * (SQ_STG - 1 - i));
    logic          vi;
    logic [QW-1:0] xi;
    logic [QW-1:0] resi;
    logic          zi;
    logic [QW-1:0] trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign vi   = in_valid;
      assign xi   = in_rad;
      assign resi = '0;
      assign zi   = in_zero;
    end else begin : g_next
      assign vi   = v_r[i-1];
      assign xi   = x_r[i-1];
      assign resi = res_r[i-1];
      assign zi   = z_r[i-1];
    end

    assign trial = resi + BITV;
    assign ge    = xi >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= vi;
      end
      x_r[i]   <= ge ? xi - trial : xi;
      res_r[i] <= ge ? (resi >> 1) + BITV : resi >> 1;
      z_r[i]   <= zi;
    end
  end

  assign out_valid = v_r[SQ_STG-1];
  assign out_root  = res_r[SQ_STG-1][SQ_STG-1:0];
  assign out_zero  = z_r[SQ_STG-1];

endmodule

>>> rtl/core/capsule_line_coverage.sv
// pipeline, default formats: 5 front stages, 16 divider stages, 4 distance stages,
//   28 square-root stages, 2 end stages
// throughput: one item per clock, busy is never raised; the divider and root are
//   fully pipelined, one bit per stage
// reset: synchronous active-low rst_n clears all valid bits and loads register defaults
// the receiver cannot stall: each result is on out_coverage for one cycle only
module capsule_line_coverage
  import clc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [IN_W-1:0]       in_pixel_x,
  input  logic [IN_W-1:0]       in_pixel_y,
  output logic                  out_valid,
  output logic [COV_W-1:0]      out_coverage,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LAT = 11 + H_FRAC + SQ_STG;
  localparam logic [COV_W-1:0] COV_HALF = COV_W'(1 << (C - 1));
  localparam logic [COV_W-1:0] COV_MAX  = COV_W'(1 << C);
  localparam logic [RS_W-1:0]  RND_C    = RS_W'((2 ** SH_R) >> 1);

  logic [CRD_W-1:0] start_x_r, start_y_r, end_x_r, end_y_r;
  logic [HW_W-1:0]  half_width_r;

  logic accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r    <= '0;
      start_y_r    <= '0;
      end_x_r      <= '0;
      end_y_r      <= '0;
      half_width_r <= HALF_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_X:    start_x_r    <= cfg_data;
        REG_START_Y:    start_y_r    <= cfg_data;
        REG_END_X:      end_x_r      <= cfg_data;
        REG_END_Y:      end_y_r      <= cfg_data;
        REG_HALF_WIDTH: half_width_r <= cfg_data[HW_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 0: capture item
  logic            v0_r;
  logic [IN_W-1:0] px0_r, py0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else        v0_r <= accept;
    px0_r <= in_pixel_x;
    py0_r <= in_pixel_y;
  end

  // stage 1: offsets from segment start
  logic                 v1_r;
  logic signed [DW-1:0] dx1_r, dy1_r, lx1_r, ly1_r;
  logic signed [DW-1:0] pxs, pys, axs, ays, bxs, bys;

  always_comb begin
    pxs = DW'($signed(px0_r)) <<< F;
    pys = DW'($signed(py0_r)) <<< F;
    axs = DW'($signed(start_x_r));
    ays = DW'($signed(start_y_r));
    bxs = DW'($signed(end_x_r));
    bys = DW'($signed(end_y_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= v0_r;
    dx1_r <= pxs - axs;
    dy1_r <= pys - ays;
    lx1_r <= bxs - axs;
    ly1_r <= bys - ays;
  end

  // stage 2: products
  logic                    v2_r;
  logic signed [NUM_W-1:0] pdx_r, pdy_r, pll_x_r, pll_y_r;
  logic signed [DW-1:0]    dx2_r, dy2_r, lx2_r, ly2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    pdx_r   <= dx1_r * lx1_r;
    pdy_r   <= dy1_r * ly1_r;
    pll_x_r <= lx1_r * lx1_r;
    pll_y_r <= ly1_r * ly1_r;
    dx2_r   <= dx1_r;
    dy2_r   <= dy1_r;
    lx2_r   <= lx1_r;
    ly2_r   <= ly1_r;
  end

  // stage 3: dot product and squared length
  logic                    v3_r;
  logic signed [SUM_W-1:0] dot3_r, len2_3_r;
  logic signed [DW-1:0]    dx3_r, dy3_r, lx3_r, ly3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    dot3_r   <= SUM_W'(pdx_r) + SUM_W'(pdy_r);
    len2_3_r <= SUM_W'(pll_x_r) + SUM_W'(pll_y_r);
    dx3_r    <= dx2_r;
    dy3_r    <= dy2_r;
    lx3_r    <= lx2_r;
    ly3_r    <= ly2_r;
  end

  // stage 4: classify projection, feed the divider
  logic             v4_r;
  logic [NUM_W-1:0] num4_r, den4_r;
  div_tag_t         tag4_r;
  h_mode_t          mode4;

  always_comb begin
    priority if (dot3_r <= 0)   mode4 = HM_ZERO;
    else if (dot3_r >= len2_3_r) mode4 = HM_FULL;
    else                         mode4 = HM_DIV;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
    num4_r      <= (mode4 == HM_DIV) ? dot3_r[NUM_W-1:0] : '0;
    den4_r      <= len2_3_r[NUM_W-1:0];
    tag4_r.zero <= (len2_3_r == '0);
    tag4_r.mode <= mode4;
    tag4_r.dx   <= dx3_r;
    tag4_r.dy   <= dy3_r;
    tag4_r.lx   <= lx3_r;
    tag4_r.ly   <= ly3_r;
  end

  // projection parameter divider
  logic              v5;
  logic [H_FRAC-1:0] quo5;
  div_tag_t          tag5;

  clc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v4_r),
    .in_num   (num4_r),
    .in_den   (den4_r),
    .in_tag   (tag4_r),
    .out_valid(v5),
    .out_quo  (quo5),
    .out_tag  (tag5)
  );

  // stage 6: scale direction by clamped h
  logic                     v6_r, z6_r;
  logic signed [H_W-1:0]    h5;
  logic signed [DW+H_W-1:0] pmx6_r, pmy6_r;
  logic signed [DW-1:0]     dx6_r, dy6_r;

  always_comb begin
    unique case (tag5.mode)
      HM_ZERO: h5 = '0;
      HM_FULL: h5 = H_W'(1) <<< H_FRAC;
      HM_DIV:  h5 = H_W'({1'b0, quo5});
      default: h5 = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else        v6_r <= v5;
    pmx6_r <= tag5.lx * h5;
    pmy6_r <= tag5.ly * h5;
    dx6_r  <= tag5.dx;
    dy6_r  <= tag5.dy;
    z6_r   <= tag5.zero;
  end

  // stage 7: offset to nearest point, magnitude rounded
  logic                  v7_r, z7_r;
  logic signed [DLW-1:0] dlx, dly;
  logic [DLW-1:0]        mgx, mgy, rx, ry;
  logic [EW-1:0]         ex7_r, ey7_r;

  always_comb begin
    dlx = (DLW'(dx6_r) <<< H_FRAC) - DLW'(pmx6_r);
    dly = (DLW'(dy6_r) <<< H_FRAC) - DLW'(pmy6_r);
    mgx = dlx[DLW-1] ? DLW'(-dlx) : DLW'(dlx);
    mgy = dly[DLW-1] ? DLW'(-dly) : DLW'(dly);
    rx  = mgx + DLW'(1 << (RND_SH - 1));
    ry  = mgy + DLW'(1 << (RND_SH - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else        v7_r <= v6_r;
    ex7_r <= rx[DLW-1:RND_SH];
    ey7_r <= ry[DLW-1:RND_SH];
    z7_r  <= z6_r;
  end

  // stage 8: squares
  logic            v8_r, z8_r;
  logic [2*EW-1:0] sqx8_r, sqy8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v8_r <= 1'b0;
    else        v8_r <= v7_r;
    sqx8_r <= ex7_r * ex7_r;
    sqy8_r <= ey7_r * ey7_r;
    z8_r   <= z7_r;
  end

  // stage 9: squared distance
  logic          v9_r, z9_r;
  logic [QW-1:0] rad9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v9_r <= 1'b0;
    else        v9_r <= v8_r;
    rad9_r <= QW'(sqx8_r) + QW'(sqy8_r);
    z9_r   <= z8_r;
  end

  // distance root
  logic              v10, z10;
  logic [SQ_STG-1:0] len10;

  clc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v9_r),
    .in_rad   (rad9_r),
    .in_zero  (z9_r),
    .out_valid(v10),
    .out_root (len10),
    .out_zero (z10)
  );

  // stage 11: coverage before rescale, clamped
  logic                 v11_r, z11_r;
  logic signed [CW-1:0] cval;
  logic [S:0]           cl11_r;

  always_comb begin
    cval = (CW'(1) <<< (S - 1)) - CW'(len10)
           + (CW'(half_width_r) <<< RND_SH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v11_r <= 1'b0;
    else        v11_r <= v10;
    priority if (cval < 0)                       cl11_r <= '0;
    else if (cval > (CW'(1) <<< S))              cl11_r <= (S+1)'(1) << S;
    else                                         cl11_r <= cval[S:0];
    z11_r <= z10;
  end

  // stage 12: rescale to output format
  logic             out_valid_r;
  logic [COV_W-1:0] out_coverage_r;
  logic [RS_W-1:0]  rs;

  always_comb begin
    rs = ((RS_W'(cl11_r) + RND_C) >> SH_R) << SH_L;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= v11_r;
    out_coverage_r <= z11_r ? COV_HALF : rs[COV_W-1:0];
  end

  assign out_valid    = out_valid_r;
  assign out_coverage = out_coverage_r;

  // every result traces back to an item accepted a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result without matching item");

  // coverage never exceeds full
  a_cov_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_coverage <= COV_MAX)
    else $error("coverage above full scale");

  // degenerate segment gives one half
  a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
    (v11_r && z11_r) |=> out_coverage == COV_HALF)
    else $error("degenerate segment coverage wrong");

endmodule
